@@ rtl/vptw_pkg.sv @@
// ----------------------------------------------------------------------------
// vptw_pkg
// shared request codes, saturation limits and helpers for the projection unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vptw_pkg;

    // request type codes
    localparam logic [1:0] REQ_MODEL  = 2'd0;
    localparam logic [1:0] REQ_PROJ   = 2'd1;
    localparam logic [1:0] REQ_POINT  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_VP_X      = 3'd0;
    localparam logic [2:0] CFG_VP_Y      = 3'd1;
    localparam logic [2:0] CFG_VP_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_VP_HEIGHT = 3'd3;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef logic signed [31:0] q_t;

    // clamp a wide signed value to 32 bits
    function automatic q_t sat64(input logic signed [63:0] v);
        q_t res;
        if (v > 64'(SAT_MAX)) begin
            res = SAT_MAX;
        end
        else if (v < 64'(SAT_MIN)) begin
            res = SAT_MIN;
        end
        else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/vptw_div.sv @@
// ----------------------------------------------------------------------------
// vptw_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vptw_div #(
    parameter int NB = 48,
    parameter int DW = 32,
    parameter int TW = 3
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [NB-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    input  wire logic [TW-1:0] in_tag,
    output logic               out_valid,
    output logic [NB-1:0]      out_quo,
    output logic [TW-1:0]      out_tag
);

    logic          vld_reg [NB];
    logic [DW-1:0] rem_reg [NB];
    logic [NB-1:0] num_reg [NB];
    logic [NB-1:0] quo_reg [NB];
    logic [DW-1:0] den_reg [NB];
    logic [TW-1:0] tag_reg [NB];

    for (genvar s = 0; s < NB; s++) begin : g_stage
        logic          prv_vld;
        logic [DW-1:0] prv_rem;
        logic [NB-1:0] prv_num;
        logic [NB-1:0] prv_quo;
        logic [DW-1:0] prv_den;
        logic [TW-1:0] prv_tag;
        logic [DW:0]   trial;
        logic [DW:0]   diff;

        if (s == 0) begin : g_first
            assign prv_vld = in_valid;
            assign prv_rem = '0;
            assign prv_num = in_num;
            assign prv_quo = '0;
            assign prv_den = in_den;
            assign prv_tag = in_tag;
        end
        else begin : g_next
            assign prv_vld = vld_reg[s-1];
            assign prv_rem = rem_reg[s-1];
            assign prv_num = num_reg[s-1];
            assign prv_quo = quo_reg[s-1];
            assign prv_den = den_reg[s-1];
            assign prv_tag = tag_reg[s-1];
        end

        // shift in next numerator bit, try subtract
        always_comb
        begin
            trial = {prv_rem, prv_num[NB-1]};
            diff  = trial - {1'b0, prv_den};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[s] <= 1'b0;
            end
            else begin
                vld_reg[s] <= prv_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (!diff[DW]) begin
                rem_reg[s] <= diff[DW-1:0];
                quo_reg[s] <= {prv_quo[NB-2:0], 1'b1};
            end
            else begin
                rem_reg[s] <= trial[DW-1:0];
                quo_reg[s] <= {prv_quo[NB-2:0], 1'b0};
            end
            num_reg[s] <= {prv_num[NB-2:0], 1'b0};
            den_reg[s] <= prv_den;
            tag_reg[s] <= prv_tag;
        end
    end

    assign out_valid = vld_reg[NB-1];
    assign out_quo   = quo_reg[NB-1];
    assign out_tag   = tag_reg[NB-1];

endmodule

`default_nettype wire

@@ rtl/vertex_project_to_window_unit.sv @@
// ----------------------------------------------------------------------------
// vertex_project_to_window_unit
// path: a point word passes stages 0 to 4, the divide pipeline and post 1 to post 3
// throughput: one word per cycle, busy never rises, done is a one-cycle strobe
// the divide pipeline (32 + FRAC_BITS stages) sets the latency
// reset: valid bits and viewport clear, both matrices return to identity
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vertex_project_to_window_unit
    import vptw_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // item channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         req_type,
    input  wire logic [3:0]         entry_index,
    input  wire logic signed [31:0] entry_value,
    input  wire logic signed [31:0] obj_x,
    input  wire logic signed [31:0] obj_y,
    input  wire logic signed [31:0] obj_z,
    // config channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    // result
    output logic                    done,
    output logic signed [31:0]      win_x,
    output logic signed [31:0]      win_y,
    output logic signed [31:0]      win_z,
    output logic                    div_fault
);

    localparam int NB = 32 + FRAC_BITS;   // quotient bits
    localparam logic signed [31:0] ONE_Q  = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [32:0] HALF_Q = 33'(64'd1 << (FRAC_BITS - 1));

    // never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    logic signed [15:0] vp_x_reg;
    logic signed [15:0] vp_y_reg;
    logic [14:0]        vp_w_reg;
    logic [14:0]        vp_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vp_x_reg <= '0;
            vp_y_reg <= '0;
            vp_w_reg <= '0;
            vp_h_reg <= '0;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_VP_X:      vp_x_reg <= cfg_data;
                CFG_VP_Y:      vp_y_reg <= cfg_data;
                CFG_VP_WIDTH:  vp_w_reg <= cfg_data[14:0];
                CFG_VP_HEIGHT: vp_h_reg <= cfg_data[14:0];
                default:       ;  // indexes past the list are dropped
            endcase
        end
    end

    // ---------------- stage 0: capture word ----------------
    logic               s0_valid_reg;
    logic [1:0]         s0_req_reg;
    logic [3:0]         s0_idx_reg;
    logic signed [31:0] s0_val_reg;
    logic signed [31:0] s0_obj_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s0_valid_reg <= 1'b0;
        end
        else begin
            s0_valid_reg <= start && !busy && (req_type != REQ_UNUSED);
        end
    end

    always_ff @(posedge clk)
    begin
        s0_req_reg    <= req_type;
        s0_idx_reg    <= entry_index;
        s0_val_reg    <= entry_value;
        s0_obj_reg[0] <= obj_x;
        s0_obj_reg[1] <= obj_y;
        s0_obj_reg[2] <= obj_z;
    end

    // ---------------- model matrix ----------------
    // model loads land here so every later point sees them, earlier ones not
    logic signed [31:0] model_reg [16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 16; i++) begin
                model_reg[i] <= (i % 5 == 0) ? ONE_Q : '0;
            end
        end
        else if (s0_valid_reg && s0_req_reg == REQ_MODEL) begin
            model_reg[s0_idx_reg] <= s0_val_reg;
        end
    end

    // ---------------- stage 1: model products ----------------
    logic               s1_valid_reg;
    logic [1:0]         s1_req_reg;
    logic [3:0]         s1_idx_reg;
    logic signed [31:0] s1_val_reg;
    logic signed [63:0] s1_prod_reg  [4][3];
    logic signed [31:0] s1_trans_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_req_reg <= s0_req_reg;
        s1_idx_reg <= s0_idx_reg;
        s1_val_reg <= s0_val_reg;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                s1_prod_reg[r][c] <= model_reg[c*4+r] * s0_obj_reg[c];
            end
            // w is exactly one, so the translation column passes unchanged
            s1_trans_reg[r] <= model_reg[12+r];
        end
    end

    // ---------------- stage 2: eye coordinates ----------------
    logic               s2_valid_reg;
    logic [1:0]         s2_req_reg;
    logic signed [31:0] s2_eye_reg [4];
    logic signed [31:0] eye_next   [4];

    always_comb
    begin
        for (int r = 0; r < 4; r++) begin
            eye_next[r] = sat64((s1_prod_reg[r][0] >>> FRAC_BITS)
                              + (s1_prod_reg[r][1] >>> FRAC_BITS)
                              + (s1_prod_reg[r][2] >>> FRAC_BITS)
                              + 64'(s1_trans_reg[r]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end
        else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_req_reg <= s1_req_reg;
        for (int r = 0; r < 4; r++) begin
            s2_eye_reg[r] <= eye_next[r];
        end
    end

    // ---------------- projection matrix ----------------
    // projection loads travel to the stage that reads the matrix
    logic signed [31:0] proj_reg [16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 16; i++) begin
                proj_reg[i] <= (i % 5 == 0) ? ONE_Q : '0;
            end
        end
        else if (s1_valid_reg && s1_req_reg == REQ_PROJ) begin
            proj_reg[s1_idx_reg] <= s1_val_reg;
        end
    end

    // ---------------- stage 3: projection products ----------------
    logic               s3_valid_reg;
    logic signed [63:0] s3_prod_reg [4][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s3_valid_reg <= 1'b0;
        end
        else begin
            s3_valid_reg <= s2_valid_reg && (s2_req_reg == REQ_POINT);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                s3_prod_reg[r][c] <= proj_reg[c*4+r] * s2_eye_reg[c];
            end
        end
    end

    // ---------------- stage 4: clip coordinates ----------------
    logic               s4_valid_reg;
    logic signed [31:0] s4_clip_reg [4];
    logic signed [31:0] clip_next   [4];

    always_comb
    begin
        for (int r = 0; r < 4; r++) begin
            clip_next[r] = sat64((s3_prod_reg[r][0] >>> FRAC_BITS)
                               + (s3_prod_reg[r][1] >>> FRAC_BITS)
                               + (s3_prod_reg[r][2] >>> FRAC_BITS)
                               + (s3_prod_reg[r][3] >>> FRAC_BITS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s4_valid_reg <= 1'b0;
        end
        else begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 4; r++) begin
            s4_clip_reg[r] <= clip_next[r];
        end
    end

    // ---------------- perspective divide ----------------
    // magnitudes go through the divider, signs ride along in the tag
    // tag: {w is zero, clip negative, quotient negative}
    logic          w_neg;
    logic          w_zero;
    logic [31:0]   w_mag;
    logic [31:0]   c_mag   [3];
    logic [NB-1:0] div_num [3];
    logic [2:0]    div_tag [3];
    logic          dv_valid [3];
    logic [NB-1:0] dv_quo   [3];
    logic [2:0]    dv_tag   [3];

    always_comb
    begin
        w_neg  = s4_clip_reg[3][31];
        w_zero = (s4_clip_reg[3] == '0);
        w_mag  = w_neg ? 32'(-s4_clip_reg[3]) : 32'(s4_clip_reg[3]);
        for (int i = 0; i < 3; i++) begin
            c_mag[i]   = s4_clip_reg[i][31] ? 32'(-s4_clip_reg[i])
                                            : 32'(s4_clip_reg[i]);
            div_num[i] = NB'(c_mag[i]) << FRAC_BITS;
            div_tag[i] = {w_zero, s4_clip_reg[i][31], s4_clip_reg[i][31] ^ w_neg};
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        vptw_div #(
            .NB (NB),
            .DW (32),
            .TW (3)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (s4_valid_reg),
            .in_num    (div_num[i]),
            .in_den    (w_mag),
            .in_tag    (div_tag[i]),
            .out_valid (dv_valid[i]),
            .out_quo   (dv_quo[i]),
            .out_tag   (dv_tag[i])
        );
    end

    // ---------------- post 1: saturate ndc, map to 0..1 ----------------
    logic               p1_valid_reg;
    logic               p1_fault_reg;
    logic               p1_cneg_reg [3];
    logic signed [32:0] p1_t_reg    [3];
    logic signed [31:0] ndc         [3];
    logic signed [32:0] t_next      [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            if (!dv_tag[i][0]) begin
                if (|dv_quo[i][NB-1:31]) begin
                    ndc[i] = SAT_MAX;
                end
                else begin
                    ndc[i] = dv_quo[i][31:0];
                end
            end
            else begin
                if ((|dv_quo[i][NB-1:32]) || (dv_quo[i][31] && |dv_quo[i][30:0])) begin
                    ndc[i] = SAT_MIN;
                end
                else begin
                    ndc[i] = 32'(-dv_quo[i][31:0]);
                end
            end
            // floor of half, then add one half
            t_next[i] = 33'(ndc[i] >>> 1) + HALF_Q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p1_valid_reg <= 1'b0;
        end
        else begin
            p1_valid_reg <= dv_valid[0];
        end
    end

    always_ff @(posedge clk)
    begin
        p1_fault_reg <= dv_tag[0][2];
        for (int i = 0; i < 3; i++) begin
            p1_t_reg[i]    <= t_next[i];
            p1_cneg_reg[i] <= dv_tag[i][1];
        end
    end

    // ---------------- post 2: viewport scale ----------------
    logic               p2_valid_reg;
    logic               p2_fault_reg;
    logic               p2_cneg_reg [3];
    logic signed [48:0] p2_sx_reg;
    logic signed [48:0] p2_sy_reg;
    logic signed [32:0] p2_tz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p2_valid_reg <= 1'b0;
        end
        else begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_fault_reg <= p1_fault_reg;
        for (int i = 0; i < 3; i++) begin
            p2_cneg_reg[i] <= p1_cneg_reg[i];
        end
        p2_sx_reg <= p1_t_reg[0] * $signed({1'b0, vp_w_reg});
        p2_sy_reg <= p1_t_reg[1] * $signed({1'b0, vp_h_reg});
        p2_tz_reg <= p1_t_reg[2];
    end

    // ---------------- post 3: origin offset, saturate, output ----------------
    logic signed [63:0] off_x;
    logic signed [63:0] off_y;
    logic signed [31:0] win_x_next;
    logic signed [31:0] win_y_next;
    logic signed [31:0] win_z_next;
    logic               done_reg;
    logic signed [31:0] win_x_reg;
    logic signed [31:0] win_y_reg;
    logic signed [31:0] win_z_reg;
    logic               fault_reg;

    always_comb
    begin
        off_x = 64'(vp_x_reg) <<< FRAC_BITS;
        off_y = 64'(vp_y_reg) <<< FRAC_BITS;
        if (p2_fault_reg) begin
            // zero w: each output pinned to the rail of its clip sign
            win_x_next = p2_cneg_reg[0] ? SAT_MIN : SAT_MAX;
            win_y_next = p2_cneg_reg[1] ? SAT_MIN : SAT_MAX;
            win_z_next = p2_cneg_reg[2] ? SAT_MIN : SAT_MAX;
        end
        else begin
            win_x_next = sat64(64'(p2_sx_reg) + off_x);
            win_y_next = sat64(64'(p2_sy_reg) + off_y);
            win_z_next = sat64(64'(p2_tz_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        win_x_reg <= win_x_next;
        win_y_reg <= win_y_next;
        win_z_reg <= win_z_next;
        fault_reg <= p2_fault_reg;
    end

    assign done      = done_reg;
    assign win_x     = win_x_reg;
    assign win_y     = win_y_reg;
    assign win_z     = win_z_reg;
    assign div_fault = fault_reg;

endmodule

`default_nettype wire

@@ rtl/vptw_check.sv @@
// ----------------------------------------------------------------------------
// vptw_check
// port level checks for the projection unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vptw_check
    import vptw_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [1:0]         req_type,
    input wire logic               done,
    input wire logic signed [31:0] win_x,
    input wire logic signed [31:0] win_y,
    input wire logic signed [31:0] win_z,
    input wire logic               div_fault
);

    localparam int LAT = 40 + FRAC_BITS;

    // every result strobe traces back to an accepted point word
    a_done_from_point: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && req_type == REQ_POINT, LAT))
        else $error("result without matching point word");

    // a clock edge in reset leaves no result strobe behind it
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("result strobe during reset");

    // divide fault pins all three outputs to a rail
    a_fault_rails: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_fault) |->
            ((win_x == SAT_MAX || win_x == SAT_MIN) &&
             (win_y == SAT_MAX || win_y == SAT_MIN) &&
             (win_z == SAT_MAX || win_z == SAT_MIN)))
        else $error("fault result not saturated");

endmodule

bind vertex_project_to_window_unit vptw_check #(.FRAC_BITS(FRAC_BITS)) u_vptw_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .done      (done),
    .win_x     (win_x),
    .win_y     (win_y),
    .win_z     (win_z),
    .div_fault (div_fault)
);

`default_nettype wire
